// ===== design/fps_pkg.sv =====
package fps_pkg;

  localparam int RateW    = 44;
  localparam int PhaseW   = 32;
  localparam int FramesW  = 13;
  localparam int BytesW   = 16;
  localparam int CntW     = 64;
  localparam int FbW      = 6;
  localparam int StatusW  = 3;
  localparam int OpW      = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 44;
  localparam int NeedW    = FramesW + FbW;

  localparam logic [RateW-1:0]  InitRateRst   = 44'd25769803776;
  localparam logic [FbW-1:0]    FrameBytesRst = 6'd4;
  localparam logic [BytesW-1:0] CapacityRst   = 16'd1024;
  localparam logic [RateW-1:0]  MaxRateRst    = {RateW{1'b1}};
  localparam logic [FbW-1:0]    FrameBytesMax = 6'd32;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_RANGE     = 3'd2,
    ST_CAPACITY  = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [OpW-1:0] {
    OP_NEXT        = 2'd0,
    OP_UPDATE      = 2'd1,
    OP_RESET_PHASE = 2'd2
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INITIAL_RATE   = 2'd0,
    REG_FRAME_BYTES    = 2'd1,
    REG_CAPACITY_BYTES = 2'd2,
    REG_MAX_RATE       = 2'd3
  } reg_idx_e;

  // Live configuration seen by the datapath.
  typedef struct packed {
    logic [FbW-1:0]    frame_bytes;
    logic [BytesW-1:0] capacity_bytes;
    logic [RateW-1:0]  max_rate;
  } cfg_t;

  // Reinitialization request issued on a configuration write.
  typedef struct packed {
    logic             load;
    logic             ready;
    logic [RateW-1:0] rate;
  } init_t;

  typedef struct packed {
    status_e            status;
    logic [FramesW-1:0] packet_frames;
    logic [BytesW-1:0]  packet_bytes;
    logic [PhaseW-1:0]  phase_out;
    logic [CntW-1:0]    packets_done;
    logic [CntW-1:0]    frames_done;
    logic [FramesW-1:0] smallest_packet;
    logic [FramesW-1:0] largest_packet;
    logic [CntW-1:0]    updates_done;
    logic [CntW-1:0]    reject_count;
  } res_t;

  // Range and capacity check of a rate; the worst case packet is the rate rounded up.
  function automatic status_e check_rate(input logic [RateW-1:0]  rate,
                                         input logic [RateW-1:0]  max_rate,
                                         input logic [FbW-1:0]    frame_bytes,
                                         input logic [BytesW-1:0] capacity_bytes);
    logic [FramesW-1:0] most;
    logic [NeedW-1:0]   need;
    status_e            st;
    most = {1'b0, rate[RateW-1:PhaseW]} + FramesW'(|rate[PhaseW-1:0]);
    need = NeedW'(most) * NeedW'(frame_bytes);
    if (rate == '0 || rate > max_rate) begin
      st = ST_RANGE;
    end else if (need > NeedW'(capacity_bytes)) begin
      st = ST_CAPACITY;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

  function automatic logic cfg_ok(input logic [RateW-1:0]  init_rate,
                                  input logic [RateW-1:0]  max_rate,
                                  input logic [FbW-1:0]    frame_bytes,
                                  input logic [BytesW-1:0] capacity_bytes);
    return (frame_bytes != '0) && (frame_bytes <= FrameBytesMax) &&
           (capacity_bytes != '0) && (capacity_bytes >= BytesW'(frame_bytes)) &&
           (check_rate(init_rate, max_rate, frame_bytes, capacity_bytes) == ST_OK);
  endfunction

endpackage

// ===== design/fps_in_if.sv =====
interface fps_in_if;
  import fps_pkg::*;

  logic                valid;
  logic                ready;
  logic [OpW-1:0]      opcode;
  logic [RateW-1:0]    new_rate;

  modport source (output valid, output opcode, output new_rate, input ready);
  modport sink   (input valid, input opcode, input new_rate, output ready);
endinterface

// ===== design/fps_out_if.sv =====
interface fps_out_if;
  import fps_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [FramesW-1:0] packet_frames;
  logic [BytesW-1:0]  packet_bytes;
  logic [PhaseW-1:0]  phase_out;
  logic [CntW-1:0]    packets_done;
  logic [CntW-1:0]    frames_done;
  logic [FramesW-1:0] smallest_packet;
  logic [FramesW-1:0] largest_packet;
  logic [CntW-1:0]    updates_done;
  logic [CntW-1:0]    reject_count;

  modport source (output valid, output status, output packet_frames, output packet_bytes,
                  output phase_out, output packets_done, output frames_done,
                  output smallest_packet, output largest_packet, output updates_done,
                  output reject_count, input ready);
  modport sink   (input valid, input status, input packet_frames, input packet_bytes,
                  input phase_out, input packets_done, input frames_done,
                  input smallest_packet, input largest_packet, input updates_done,
                  input reject_count, output ready);
endinterface

// ===== design/feedback_packet_size_scheduler.sv =====
// Isochronous packet sizer. Each request transfer on in_i carries an opcode: next packet adds
// the current Q12.32 rate to a 32-bit fractional phase and reports the carry as the packet's
// frame count and frames times frame_bytes as its byte count; update rate checks and loads
// new_rate; reset phase clears the phase. Exactly one result transfer on out_o follows every
// request, in order, carrying a status and a snapshot of the phase and all counters after
// that request. The block takes one request per clock cycle, back to back, while results are
// accepted, and a result appears on out_o once its request has passed the input register and
// then the result register; the whole state update of a request, a 44-bit accumulate, a 13x6
// multiply with capacity compare and the 64-bit counter updates, is combinational between them.
// A stalled result holds in the result register while one more request may still be taken.
// Any configuration write clears all state and rechecks the settings; write only while idle.
module feedback_packet_size_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fps_pkg::CfgDataW-1:0]  cfg_data_i,
  fps_in_if.sink                        in_i,
  fps_out_if.source                     out_o
);
  import fps_pkg::*;

  cfg_t  cfg;
  init_t init;
  res_t  res;
  logic  res_vld;
  logic  res_rdy;

  // Configuration registers; a write also requests a full reinitialization of the state.
  fps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .init_o     (init)
  );

  // Input register, accumulator, counters and the combinational state update.
  fps_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .init_i    (init),
    .in_i      (in_i),
    .res_rdy_i (res_rdy),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Result register that decouples the consumer from the datapath.
  fps_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_vld_i (res_vld),
    .res_i     (res),
    .res_rdy_o (res_rdy),
    .out_o     (out_o)
  );

endmodule

// ===== design/fps_cfg.sv =====
module fps_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fps_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fps_pkg::CfgDataW-1:0]  cfg_data_i,
  output fps_pkg::cfg_t                 cfg_o,
  output fps_pkg::init_t                init_o
);
  import fps_pkg::*;

  logic [RateW-1:0]  init_rate_q, init_rate_d;
  logic [FbW-1:0]    frame_bytes_q, frame_bytes_d;
  logic [BytesW-1:0] capacity_q, capacity_d;
  logic [RateW-1:0]  max_rate_q, max_rate_d;
  logic              ok;

  always_comb begin
    init_rate_d   = init_rate_q;
    frame_bytes_d = frame_bytes_q;
    capacity_d    = capacity_q;
    max_rate_d    = max_rate_q;
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_INITIAL_RATE:   init_rate_d   = cfg_data_i[RateW-1:0];
        REG_FRAME_BYTES:    frame_bytes_d = cfg_data_i[FbW-1:0];
        REG_CAPACITY_BYTES: capacity_d    = cfg_data_i[BytesW-1:0];
        REG_MAX_RATE:       max_rate_d    = cfg_data_i[RateW-1:0];
        default: ;
      endcase
    end
  end

  // The new settings are checked in the same cycle they are written.
  assign ok          = cfg_ok(init_rate_d, max_rate_d, frame_bytes_d, capacity_d);
  assign init_o.load  = cfg_we_i;
  assign init_o.ready = ok;
  assign init_o.rate  = ok ? init_rate_d : '0;

  assign cfg_o.frame_bytes    = frame_bytes_q;
  assign cfg_o.capacity_bytes = capacity_q;
  assign cfg_o.max_rate       = max_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_rate_q   <= InitRateRst;
      frame_bytes_q <= FrameBytesRst;
      capacity_q    <= CapacityRst;
      max_rate_q    <= MaxRateRst;
    end else begin
      init_rate_q   <= init_rate_d;
      frame_bytes_q <= frame_bytes_d;
      capacity_q    <= capacity_d;
      max_rate_q    <= max_rate_d;
    end
  end

endmodule

// ===== design/fps_core.sv =====
module fps_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fps_pkg::cfg_t  cfg_i,
  input  fps_pkg::init_t init_i,
  fps_in_if.sink         in_i,
  input  logic           res_rdy_i,
  output logic           res_vld_o,
  output fps_pkg::res_t  res_o
);
  import fps_pkg::*;

  localparam logic RstReady = cfg_ok(InitRateRst, MaxRateRst, FrameBytesRst, CapacityRst);
  localparam logic [RateW-1:0] RstRate = RstReady ? InitRateRst : '0;

  // Input register.
  logic             vld_q;
  logic [OpW-1:0]   op_q;
  logic [RateW-1:0] new_rate_q;
  logic             adv;
  logic             take;

  // Architectural state.
  logic               ready_q, ready_d;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [RateW-1:0]   rate_q, rate_d;
  logic [CntW-1:0]    pkt_q, pkt_d;
  logic [CntW-1:0]    frm_q, frm_d;
  logic [FramesW-1:0] min_q, min_d;
  logic [FramesW-1:0] max_q, max_d;
  logic [CntW-1:0]    upd_q, upd_d;
  logic [CntW-1:0]    rej_q, rej_d;

  logic [RateW:0]     sum;
  logic [FramesW-1:0] frames;
  logic [NeedW-1:0]   bytes;
  logic               cap_fail;
  logic [CntW:0]      frm_sum;
  logic [CntW-1:0]    rej_inc;
  status_e            chk;
  status_e            status;
  logic [FramesW-1:0] frames_out;
  logic [BytesW-1:0]  bytes_out;

  assign adv        = vld_q & res_rdy_i;
  assign take       = in_i.valid & in_i.ready;
  assign in_i.ready = ~vld_q | adv;
  assign res_vld_o  = vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (adv) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q       <= in_i.opcode;
      new_rate_q <= in_i.new_rate;
    end
  end

  assign sum      = {1'b0, rate_q} + (RateW+1)'(phase_q);
  assign frames   = sum[RateW:PhaseW];
  assign bytes    = NeedW'(frames) * NeedW'(cfg_i.frame_bytes);
  assign cap_fail = bytes > NeedW'(cfg_i.capacity_bytes);
  assign frm_sum  = {1'b0, frm_q} + (CntW+1)'(frames);
  assign rej_inc  = (&rej_q) ? rej_q : rej_q + CntW'(1);
  assign chk      = check_rate(new_rate_q, cfg_i.max_rate, cfg_i.frame_bytes,
                               cfg_i.capacity_bytes);

  always_comb begin
    ready_d    = ready_q;
    phase_d    = phase_q;
    rate_d     = rate_q;
    pkt_d      = pkt_q;
    frm_d      = frm_q;
    min_d      = min_q;
    max_d      = max_q;
    upd_d      = upd_q;
    rej_d      = rej_q;
    status     = ST_OK;
    frames_out = '0;
    bytes_out  = '0;
    unique case (op_q)
      OP_NEXT: begin
        if (!ready_q) begin
          status = ST_NOT_READY;
        end else if (cap_fail) begin
          status = ST_CAPACITY;
          rej_d  = rej_inc;
        end else if ((&pkt_q) || frm_sum[CntW]) begin
          status = ST_OVERFLOW;
        end else begin
          phase_d = sum[PhaseW-1:0];
          pkt_d   = pkt_q + CntW'(1);
          frm_d   = frm_sum[CntW-1:0];
          // The first packet always sets the minimum.
          if (pkt_q == '0 || frames < min_q) begin
            min_d = frames;
          end
          if (frames > max_q) begin
            max_d = frames;
          end
          frames_out = frames;
          bytes_out  = bytes[BytesW-1:0];
        end
      end
      OP_UPDATE: begin
        if (!ready_q) begin
          status = ST_NOT_READY;
        end else begin
          status = chk;
          if (chk == ST_CAPACITY) begin
            rej_d = rej_inc;
          end else if (chk == ST_OK) begin
            if (&upd_q) begin
              status = ST_OVERFLOW;
            end else begin
              rate_d = new_rate_q;
              upd_d  = upd_q + CntW'(1);
            end
          end
        end
      end
      OP_RESET_PHASE: begin
        phase_d = '0;
      end
      default: ;
    endcase
  end

  assign res_o.status          = status;
  assign res_o.packet_frames   = frames_out;
  assign res_o.packet_bytes    = bytes_out;
  assign res_o.phase_out       = phase_d;
  assign res_o.packets_done    = pkt_d;
  assign res_o.frames_done     = frm_d;
  assign res_o.smallest_packet = min_d;
  assign res_o.largest_packet  = max_d;
  assign res_o.updates_done    = upd_d;
  assign res_o.reject_count    = rej_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= RstReady;
      phase_q <= '0;
      rate_q  <= RstRate;
      pkt_q   <= '0;
      frm_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      upd_q   <= '0;
      rej_q   <= '0;
    end else if (init_i.load) begin
      ready_q <= init_i.ready;
      phase_q <= '0;
      rate_q  <= init_i.rate;
      pkt_q   <= '0;
      frm_q   <= '0;
      min_q   <= '0;
      max_q   <= '0;
      upd_q   <= '0;
      rej_q   <= '0;
    end else if (adv) begin
      ready_q <= ready_d;
      phase_q <= phase_d;
      rate_q  <= rate_d;
      pkt_q   <= pkt_d;
      frm_q   <= frm_d;
      min_q   <= min_d;
      max_q   <= max_d;
      upd_q   <= upd_d;
      rej_q   <= rej_d;
    end
  end

endmodule

// ===== design/fps_outbuf.sv =====
module fps_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_vld_i,
  input  fps_pkg::res_t res_i,
  output logic          res_rdy_o,
  fps_out_if.source     out_o
);
  import fps_pkg::*;

  logic out_vld_q;
  res_t res_q;
  logic load;

  assign res_rdy_o = ~out_vld_q | out_o.ready;
  assign load      = res_vld_i & res_rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.status          = res_q.status;
  assign out_o.packet_frames   = res_q.packet_frames;
  assign out_o.packet_bytes    = res_q.packet_bytes;
  assign out_o.phase_out       = res_q.phase_out;
  assign out_o.packets_done    = res_q.packets_done;
  assign out_o.frames_done     = res_q.frames_done;
  assign out_o.smallest_packet = res_q.smallest_packet;
  assign out_o.largest_packet  = res_q.largest_packet;
  assign out_o.updates_done    = res_q.updates_done;
  assign out_o.reject_count    = res_q.reject_count;

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fps_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 7;
  // Cycles without any transfer before the run is declared hung. The worst legitimate quiet
  // stretch is a register programming pass plus a long random receiver stall, so this leaves a
  // wide margin.
  localparam int StallLimit  = 2000;
  // The block answers once a request has passed its input and result registers; this covers it.
  localparam int SettleCycles = 4;
  localparam int BusyPct     = 54;
  localparam int SharedPct   = 21;

  // The opcode field is two bits wide, so the fourth code is legal on the bus and must be
  // answered as a no-op.
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam logic [CntW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [RateW-1:0] rate;
  } request_t;

  typedef struct packed {
    logic [RateW-1:0]  init_rate;
    logic [FbW-1:0]    frame_bytes;
    logic [BytesW-1:0] capacity;
    logic [RateW-1:0]  max_rate;
  } settings_t;

  // Every block input gets a known value at time zero through these initializers.
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                req_valid  = 1'b0;
  logic [OpW-1:0]      req_op     = '0;
  logic [RateW-1:0]    req_rate   = '0;
  logic                rsp_ready  = 1'b0;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  request_t requests_to_send[$];
  res_t     packet_reports_due[$];

  fps_in_if  req_bus ();
  fps_out_if rsp_bus ();

  assign req_bus.valid    = req_valid;
  assign req_bus.opcode   = req_op;
  assign req_bus.new_rate = req_rate;
  assign rsp_bus.ready    = rsp_ready;

  feedback_packet_size_scheduler i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (req_bus),
    .out_o      (rsp_bus)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Shadow of the register file and of the scheduler state. These are updated at the same
  // clock edges at which the block sees a register write or takes a request.
  logic [RateW-1:0]   cfg_init_rate;
  logic [FbW-1:0]     cfg_frame_bytes;
  logic [BytesW-1:0]  cfg_capacity;
  logic [RateW-1:0]   cfg_max_rate;

  logic               sched_ready;
  logic [PhaseW-1:0]  sched_phase;
  logic [RateW-1:0]   sched_rate;
  logic [CntW-1:0]    packet_total;
  logic [CntW-1:0]    frame_total;
  logic [CntW-1:0]    update_total;
  logic [CntW-1:0]    reject_total;
  logic [FramesW-1:0] fewest_frames;
  logic [FramesW-1:0] most_frames;

  // A rate is out of range when it is zero or above max_rate. Otherwise the worst packet it
  // can produce is the rate rounded up to whole frames, and that packet must fit the endpoint.
  function automatic status_e rate_verdict(logic [RateW-1:0] rate);
    logic [63:0] worst_frames;
    if (rate == '0 || rate > cfg_max_rate) begin
      return ST_RANGE;
    end
    worst_frames = 64'(rate[RateW-1:PhaseW]) + 64'(rate[PhaseW-1:0] != '0);
    if (worst_frames * 64'(cfg_frame_bytes) > 64'(cfg_capacity)) begin
      return ST_CAPACITY;
    end
    return ST_OK;
  endfunction

  // Reset and every register write wipe the state and then decide whether the settings
  // allow scheduling at all.
  function automatic void restart_schedule();
    sched_ready   = 1'b0;
    sched_phase   = '0;
    sched_rate    = '0;
    packet_total  = '0;
    frame_total   = '0;
    update_total  = '0;
    reject_total  = '0;
    fewest_frames = '0;
    most_frames   = '0;
    if (cfg_frame_bytes != '0 && cfg_frame_bytes <= FrameBytesMax && cfg_capacity != '0 &&
        cfg_capacity >= BytesW'(cfg_frame_bytes) && rate_verdict(cfg_init_rate) == ST_OK) begin
      sched_rate  = cfg_init_rate;
      sched_ready = 1'b1;
    end
  endfunction

  function automatic void count_reject();
    if (reject_total != CountMax) begin
      reject_total++;
    end
  endfunction

  // Applies one request to the shadow state and returns the report the block must send.
  function automatic res_t schedule_request(request_t req);
    res_t               rep;
    status_e            st;
    logic [63:0]        sum;
    logic [63:0]        carry;
    logic [63:0]        span;
    logic [FramesW-1:0] out_frames;
    logic [BytesW-1:0]  out_bytes;
    st         = ST_OK;
    out_frames = '0;
    out_bytes  = '0;
    case (req.op)
      OP_NEXT: begin
        if (!sched_ready) begin
          st = ST_NOT_READY;
        end else begin
          // The carry out of the 32-bit phase is the packet's frame count.
          sum   = 64'(sched_phase) + 64'(sched_rate);
          carry = sum >> PhaseW;
          span  = carry * 64'(cfg_frame_bytes);
          if (span > 64'(cfg_capacity)) begin
            st = ST_CAPACITY;
            count_reject();
          end else if (packet_total == CountMax || carry > CountMax - frame_total) begin
            st = ST_OVERFLOW;
          end else begin
            sched_phase = sum[PhaseW-1:0];
            packet_total++;
            frame_total += carry;
            if (packet_total == 64'd1 || carry < 64'(fewest_frames)) begin
              fewest_frames = FramesW'(carry);
            end
            if (carry > 64'(most_frames)) begin
              most_frames = FramesW'(carry);
            end
            out_frames = FramesW'(carry);
            out_bytes  = BytesW'(span);
          end
        end
      end
      OP_UPDATE: begin
        if (!sched_ready) begin
          st = ST_NOT_READY;
        end else begin
          st = rate_verdict(req.rate);
          if (st == ST_CAPACITY) begin
            count_reject();
          end else if (st == ST_OK) begin
            if (update_total == CountMax) begin
              st = ST_OVERFLOW;
            end else begin
              sched_rate = req.rate;
              update_total++;
            end
          end
        end
      end
      // Clearing the phase works even when the settings are invalid.
      OP_RESET_PHASE: begin
        sched_phase = '0;
      end
      default: begin
      end
    endcase
    rep.status          = st;
    rep.packet_frames   = out_frames;
    rep.packet_bytes    = out_bytes;
    rep.phase_out       = sched_phase;
    rep.packets_done    = packet_total;
    rep.frames_done     = frame_total;
    rep.smallest_packet = fewest_frames;
    rep.largest_packet  = most_frames;
    rep.updates_done    = update_total;
    rep.reject_count    = reject_total;
    return rep;
  endfunction

  function automatic int compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got === want) begin
      return 0;
    end
    $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    return 1;
  endfunction

  // Rates for update requests. Most of them land inside the legal window of the current
  // settings, with whole-frame rates and the first rate past the window to hit the capacity
  // boundary; the rest are zero, small rates of at most two frames or fully random 44-bit values.
  function automatic logic [RateW-1:0] pick_update_rate();
    logic [63:0] raw;
    logic [63:0] whole;
    logic [63:0] ceiling;
    raw   = {$urandom, $urandom};
    whole = (cfg_frame_bytes == '0) ? 64'd0 : 64'(cfg_capacity) / 64'(cfg_frame_bytes);
    if (whole > 64'd4096) begin
      whole = 64'd4096;
    end
    ceiling = whole << PhaseW;
    if (ceiling > 64'(cfg_max_rate)) begin
      ceiling = 64'(cfg_max_rate);
    end
    case ($urandom_range(9))
      0: return RateW'(raw);
      1: return '0;
      2: return RateW'(ceiling + 64'd1);
      3: begin
        if (whole == 64'd0) begin
          return RateW'(raw);
        end
        return RateW'(((64'(raw[31:0]) % whole + 64'd1) << PhaseW) + 64'(raw[32]));
      end
      4: return RateW'(raw[PhaseW:0]) + RateW'(1);
      default: begin
        if (ceiling == 64'd0) begin
          return RateW'(raw);
        end
        return RateW'(raw % ceiling + 64'd1);
      end
    endcase
  endfunction

  // Mostly packet requests and rate updates, with occasional phase clears and the unused
  // opcode mixed in as noise.
  function automatic request_t random_request();
    request_t req;
    int       pick;
    pick     = $urandom_range(99);
    req.rate = RateW'({$urandom, $urandom});
    if (pick < 55) begin
      req.op = OP_NEXT;
    end else if (pick < 82) begin
      req.op   = OP_UPDATE;
      req.rate = pick_update_rate();
    end else if (pick < 93) begin
      req.op = OP_RESET_PHASE;
    end else begin
      req.op = OpUnused;
    end
    return req;
  endfunction

  function automatic void send(logic [OpW-1:0] op, logic [RateW-1:0] rate);
    requests_to_send.push_back('{op: op, rate: rate});
  endfunction

  // Request driver. A new request is presented only once the previous one has been
  // transferred, and the sender may hold off between requests at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_bus.ready) begin
      if (requests_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        req_valid         <= 1'b1;
        {req_op, req_rate} <= requests_to_send.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver side: ready is redrawn every cycle, so stalls land on every stage of the
  // block's pipeline, including while a second request is queued behind a held result.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor. Register writes and request transfers update the shadow model, and each result
  // transfer is checked against the oldest outstanding report. The expectation of a request
  // is queued before the result check so that ordering holds for any latency.
  always @(posedge clk_i) begin
    res_t want;
    if (!rst_ni) begin
      cfg_init_rate   = InitRateRst;
      cfg_frame_bytes = FrameBytesRst;
      cfg_capacity    = CapacityRst;
      cfg_max_rate    = MaxRateRst;
      restart_schedule();
      quiet_cycles = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_INITIAL_RATE:   cfg_init_rate   = cfg_data_i[RateW-1:0];
          REG_FRAME_BYTES:    cfg_frame_bytes = cfg_data_i[FbW-1:0];
          REG_CAPACITY_BYTES: cfg_capacity    = cfg_data_i[BytesW-1:0];
          REG_MAX_RATE:       cfg_max_rate    = cfg_data_i[RateW-1:0];
          default: begin
          end
        endcase
        restart_schedule();
      end
      if (req_valid && req_bus.ready) begin
        packet_reports_due.push_back(schedule_request('{op: req_op, rate: req_rate}));
      end
      if (rsp_bus.valid && rsp_ready) begin
        if (packet_reports_due.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatches++;
        end else begin
          want = packet_reports_due.pop_front();
          mismatches += compare_field("status", want.status, rsp_bus.status);
          mismatches += compare_field("packet_frames", want.packet_frames,
                                      rsp_bus.packet_frames);
          mismatches += compare_field("packet_bytes", want.packet_bytes, rsp_bus.packet_bytes);
          mismatches += compare_field("phase_out", want.phase_out, rsp_bus.phase_out);
          mismatches += compare_field("packets_done", want.packets_done, rsp_bus.packets_done);
          mismatches += compare_field("frames_done", want.frames_done, rsp_bus.frames_done);
          mismatches += compare_field("smallest_packet", want.smallest_packet,
                                      rsp_bus.smallest_packet);
          mismatches += compare_field("largest_packet", want.largest_packet,
                                      rsp_bus.largest_packet);
          mismatches += compare_field("updates_done", want.updates_done, rsp_bus.updates_done);
          mismatches += compare_field("reject_count", want.reject_count, rsp_bus.reject_count);
        end
      end
      // Watchdog: any transfer on either channel counts as progress.
      if ((req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Blocks until every queued request has been transferred and every report has come back,
  // then lets the pipeline settle before anyone touches the registers.
  task automatic wait_for_quiet();
    while (requests_to_send.size() != 0 || req_valid || packet_reports_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all four registers on back-to-back cycles. Write enable stays high across the
  // burst and drops once after the last one.
  task automatic program_regs(settings_t s);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_INITIAL_RATE;
    cfg_data_i <= CfgDataW'(s.init_rate);
    @(posedge clk_i);
    cfg_idx_i  <= REG_FRAME_BYTES;
    cfg_data_i <= CfgDataW'(s.frame_bytes);
    @(posedge clk_i);
    cfg_idx_i  <= REG_CAPACITY_BYTES;
    cfg_data_i <= CfgDataW'(s.capacity);
    @(posedge clk_i);
    cfg_idx_i  <= REG_MAX_RATE;
    cfg_data_i <= CfgDataW'(s.max_rate);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    // A further wait lets the shadow registers hold the last write before rates are drawn.
    @(posedge clk_i);
  endtask

  task automatic run_phase(settings_t s, idle_mode_e mode, int count);
    program_regs(s);
    case (mode)
      IDLE_SEND: begin
        send_gap_pct   = BusyPct;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_gap_pct   = 0;
        recv_stall_pct = BusyPct;
      end
      IDLE_BOTH: begin
        send_gap_pct   = SharedPct;
        recv_stall_pct = SharedPct;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
    repeat (count) requests_to_send.push_back(random_request());
    wait_for_quiet();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset settings: 6.0 frames per interval, 4 bytes per frame,
    // 1024 byte capacity, so at most 256 whole frames fit.
    send(OP_NEXT, '0);
    send(OP_UPDATE, '0);                       // zero rate is out of range
    send(OP_UPDATE, 44'hFFF_FFFF_FFFF);        // largest rate, far over capacity
    send(OP_UPDATE, 44'h100_0000_0000);        // exactly fills the endpoint
    send(OP_NEXT, '0);
    send(OP_UPDATE, 44'h100_0000_0001);        // one fraction over rounds up past capacity
    send(OP_UPDATE, 44'd1);                    // smallest legal rate
    send(OP_NEXT, '0);                         // empty packet
    send(OP_UPDATE, 44'h000_FFFF_FFFF);
    send(OP_NEXT, '0);                         // phase wraps exactly to zero
    send(OP_NEXT, '0);                         // phase ends at all ones
    send(OP_RESET_PHASE, 44'hFFF_FFFF_FFFF);
    send(OpUnused, 44'hFFF_FFFF_FFFF);
    send(OP_UPDATE, 44'h001_8000_0000);        // 1.5 frames: alternating packet sizes
    repeat (4) send(OP_NEXT, '0);
    send(OP_RESET_PHASE, '0);
    send(OP_UPDATE, 44'h800_0000_0000);        // top rate bit alone
    send(OP_NEXT, '0);
    wait_for_quiet();

    // Random phases. Ready settings get most of the traffic; invalid settings check that
    // packets and updates answer not ready while phase clears still work.
    run_phase('{44'h030_2000_0000, 6'd4, 16'd1024, MaxRateRst}, IDLE_SEND, 80);
    // Largest rate with one byte per frame: packets of 4095 and 4096 frames.
    run_phase('{44'hFFF_FFFF_FFFF, 6'd1, 16'd4096, MaxRateRst}, IDLE_RECV, 80);
    run_phase('{44'd1, 6'd32, 16'hFFFF, MaxRateRst}, IDLE_BOTH, 80);
    // Smallest max_rate and capacity: only a rate of one LSB is legal.
    run_phase('{44'd1, 6'd1, 16'd1, 44'd1}, IDLE_NONE, 40);
    run_phase('{44'h003_0000_0000, 6'd0, 16'd1024, MaxRateRst}, IDLE_SEND, 20);
    run_phase('{44'h003_0000_0000, 6'd33, 16'd1024, MaxRateRst}, IDLE_RECV, 20);
    run_phase('{44'h003_0000_0000, 6'd63, 16'hFFFF, MaxRateRst}, IDLE_BOTH, 20);
    run_phase('{44'h003_0000_0000, 6'd4, 16'd0, MaxRateRst}, IDLE_NONE, 20);
    run_phase('{44'h001_0000_0000, 6'd8, 16'd7, MaxRateRst}, IDLE_SEND, 20);
    run_phase('{44'h00A_0000_0000, 6'd4, 16'd1024, 44'h005_0000_0000}, IDLE_RECV, 20);
    run_phase('{44'h0C8_0000_0001, 6'd5, 16'd1000, MaxRateRst}, IDLE_BOTH, 20);
    // Here max_rate and capacity bound the legal rates at the same point, and the range check answers first.
    run_phase('{44'h011_5555_5555, 6'd24, 16'd480, 44'h014_0000_0000}, IDLE_BOTH, 80);
    run_phase('{44'h005_C000_0000, 6'd12, 16'd1536, MaxRateRst}, IDLE_SEND, 60);

    if (mismatches == 0 && packet_reports_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fps_pkg.sv
design/fps_in_if.sv
design/fps_out_if.sv
design/fps_cfg.sv
design/fps_core.sv
design/fps_outbuf.sv
design/feedback_packet_size_scheduler.sv
tb/testbench.sv
